@@ rtl/hefs_pkg.sv @@
// shared types and constants of the ftcs heat-equation stepper
// depends on nothing; used by hefs_update and heat_equation_ftcs_step
package hefs_pkg;

   localparam int MAX_POINTS_DEFAULT  = 64;
   localparam int VALUE_WIDTH_DEFAULT = 24;

   localparam int LAM_WIDTH         = 16;
   localparam int FRAC_BITS         = 16;
   localparam int COEF_WIDTH        = 18;
   localparam int NUM_POINTS_WIDTH  = 7;
   localparam int POINT_INDEX_WIDTH = 6;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 16;
   localparam int MIN_POINTS        = 3;

   localparam logic [LAM_WIDTH-1:0]        LAM_RESET        = 16'd33200;
   localparam logic [NUM_POINTS_WIDTH-1:0] NUM_POINTS_RESET = 7'd11;

   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LAM        = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NUM_POINTS = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SWEEP = 3'b010,
      ST_DRAIN = 3'b100
   } seq_state_type;

   // per-point control traveling down the update pipeline
   typedef struct packed {
      logic interior;
      logic last;
   } point_tag_type;

endpackage

@@ rtl/hefs_update.sv @@
// point update stage: registered products, floor, add and saturate
// depends on hefs_pkg
module hefs_update #(
   parameter int VALUE_WIDTH = hefs_pkg::VALUE_WIDTH_DEFAULT,
   parameter int IDX_W       = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              go,
   input  logic                              in_valid,
   input  hefs_pkg::point_tag_type           in_tag,
   input  logic [IDX_W-1:0]                  in_idx,
   input  logic signed [VALUE_WIDTH-1:0]     in_cur,
   input  logic signed [VALUE_WIDTH:0]       in_sum,
   input  logic [hefs_pkg::LAM_WIDTH-1:0]    lam,
   output logic                              out_valid,
   output hefs_pkg::point_tag_type           out_tag,
   output logic [IDX_W-1:0]                  out_idx,
   output logic signed [VALUE_WIDTH-1:0]     out_value
);
   import hefs_pkg::*;

   localparam int PROD_W = VALUE_WIDTH + COEF_WIDTH;
   localparam int SUM_W  = VALUE_WIDTH + 3;
   localparam logic signed [SUM_W-1:0] VAL_MAX =
      SUM_W'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] VAL_MIN = -VAL_MAX - SUM_W'(1);

   logic signed [COEF_WIDTH-1:0]  coef_ff, coef_in;
   logic signed [LAM_WIDTH:0]     lam_s;
   logic signed [PROD_W-1:0]      prod_c_in, prod_k_in, prod_c_ff, prod_k_ff;
   logic signed [PROD_W-1:0]      sh_c, sh_k;
   logic signed [SUM_W-1:0]       total;
   logic signed [VALUE_WIDTH-1:0] cur_ff, sat_value;
   logic                          valid_ff;
   point_tag_type                 tag_ff;
   logic [IDX_W-1:0]              idx_ff;

   // c = 1 - 2*lam in q1.16
   assign coef_in   = $signed(COEF_WIDTH'(1 << FRAC_BITS))
                    - $signed({1'b0, lam, 1'b0});
   assign lam_s     = $signed({1'b0, lam});
   assign prod_c_in = coef_ff * in_cur;
   assign prod_k_in = lam_s * in_sum;

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (go) begin
         valid_ff <= in_valid;
      end
      if (go) begin
         prod_c_ff <= prod_c_in;
         prod_k_ff <= prod_k_in;
         cur_ff    <= in_cur;
         tag_ff    <= in_tag;
         idx_ff    <= in_idx;
      end
   end

   // arithmetic shift is floor division of each exact product
   assign sh_c  = prod_c_ff >>> FRAC_BITS;
   assign sh_k  = prod_k_ff >>> FRAC_BITS;
   assign total = SUM_W'(sh_c) + SUM_W'(sh_k);

   always_comb begin
      if (total > VAL_MAX) begin
         sat_value = VALUE_WIDTH'(VAL_MAX);
      end else if (total < VAL_MIN) begin
         sat_value = VALUE_WIDTH'(VAL_MIN);
      end else begin
         sat_value = VALUE_WIDTH'(total);
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;
   assign out_idx   = idx_ff;
   assign out_value = tag_ff.interior ? sat_value : cur_ff;

endmodule

@@ rtl/heat_equation_ftcs_step.sv @@
// top level of the one-dimensional ftcs heat-equation stepper
// depends on hefs_pkg and hefs_update
//
// The grid lives in one synchronous memory of MAX_POINTS entries. A load request
// (kind 0) writes the next grid value at the load pointer; the pointer wraps after
// the last point in use. An advance request (kind 1) makes one sweep over the grid:
// one memory read per cycle while the result side does not stall, old neighbor
// values kept in a two-entry window, so every interior point is computed from old
// values only, and each point is emitted in index order as it leaves the pipeline,
// interior points also being written back. The end points are emitted unchanged;
// the final result has rsp_last set. An advance uses num_points + 1 read slots of
// the single memory read port plus the pipeline drain; stalls on the result side
// stall the whole sweep. New requests are taken only when no sweep is in flight,
// and the next load after an advance starts at point 0. num_points below 3 is used
// as 3, above MAX_POINTS as MAX_POINTS. Grid entries never loaded since reset read
// as unknown values.
module heat_equation_ftcs_step #(
   parameter int MAX_POINTS  = hefs_pkg::MAX_POINTS_DEFAULT,
   parameter int VALUE_WIDTH = hefs_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // request channel
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic                                      req_kind,
   input  logic signed [VALUE_WIDTH-1:0]             req_value,
   // result channel
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [hefs_pkg::POINT_INDEX_WIDTH-1:0]    rsp_point_index,
   output logic signed [VALUE_WIDTH-1:0]             rsp_point_value,
   output logic                                      rsp_last,
   // register write channel
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [hefs_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [hefs_pkg::CSR_DATA_WIDTH-1:0]       csr_wdata
);
   import hefs_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   // configuration registers
   logic [LAM_WIDTH-1:0]        lam_ff;
   logic [NUM_POINTS_WIDTH-1:0] num_points_ff;
   logic [CNT_W-1:0]            n_eff;

   // sequencer
   seq_state_type    state_ff, state_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             go;
   logic             issue_fire;
   logic             issue_last;
   logic             req_fire;

   // load pointer
   logic [IDX_W-1:0] lp_ff, lp_in, lp_start;
   logic [CNT_W-1:0] lp_next_cnt;

   // grid memory
   logic signed [VALUE_WIDTH-1:0] grid_mem [MAX_POINTS];
   logic [IDX_W-1:0]              rd_addr;
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic signed [VALUE_WIDTH-1:0] wr_data;

   // read slot stage and the old-value window
   logic                          s1_valid_ff;
   logic [CNT_W-1:0]              s1_slot_ff;
   logic signed [VALUE_WIDTH-1:0] left_old_ff, win_cur_ff;

   // operand stage
   logic                          a_valid_ff;
   point_tag_type                 a_tag_ff;
   logic [IDX_W-1:0]              a_idx_ff;
   logic signed [VALUE_WIDTH-1:0] a_cur_ff;
   logic signed [VALUE_WIDTH:0]   a_sum_ff;

   // update unit output
   logic                          b_valid;
   point_tag_type                 b_tag;
   logic [IDX_W-1:0]              b_idx;
   logic signed [VALUE_WIDTH-1:0] b_value;
   logic                          sweep_wr;

   // result register
   logic                          rsp_valid_ff;
   logic [POINT_INDEX_WIDTH-1:0]  rsp_index_ff;
   logic signed [VALUE_WIDTH-1:0] rsp_value_ff;
   logic                          rsp_last_ff;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lam_ff        <= LAM_RESET;
         num_points_ff <= NUM_POINTS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LAM:        lam_ff        <= csr_wdata[LAM_WIDTH-1:0];
            CSR_NUM_POINTS: num_points_ff <= csr_wdata[NUM_POINTS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // clamp the point count into the usable range
   always_comb begin
      if (int'(num_points_ff) < MIN_POINTS) begin
         n_eff = CNT_W'(MIN_POINTS);
      end else if (int'(num_points_ff) > MAX_POINTS) begin
         n_eff = CNT_W'(MAX_POINTS);
      end else begin
         n_eff = CNT_W'(num_points_ff);
      end
   end

   // ---------------------------------------------------------------- control
   // every pipeline stage moves only when the result register can take a value
   assign go         = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign issue_fire = (state_ff == ST_SWEEP) && go;
   // the slot after the last point reads address 0 but uses no data from it, it only flushes the window
   assign issue_last = (issue_ff == n_eff);

   always_comb begin
      state_in = state_ff;
      issue_in = issue_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_kind == KIND_ADVANCE) begin
               state_in = ST_SWEEP;
               issue_in = '0;
            end
         end
         ST_SWEEP: begin
            if (go) begin
               issue_in = issue_ff + CNT_W'(1);
               if (issue_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // wait until the last point has left the update unit for the result register
            if (!s1_valid_ff && !a_valid_ff && !b_valid) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issue_ff <= '0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue_in;
      end
   end

   // load pointer, wrapped at the point count in use
   assign lp_start    = (CNT_W'(lp_ff) >= n_eff) ? '0 : lp_ff;
   assign lp_next_cnt = CNT_W'(lp_start) + CNT_W'(1);

   always_comb begin
      lp_in = lp_ff;
      if (req_fire) begin
         if (req_kind == KIND_ADVANCE) begin
            lp_in = '0;
         end else if (lp_next_cnt >= n_eff) begin
            lp_in = '0;
         end else begin
            lp_in = IDX_W'(lp_next_cnt);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ff <= '0;
      end else begin
         lp_ff <= lp_in;
      end
   end

   // ---------------------------------------------------------------- memory
   assign rd_addr  = issue_last ? '0 : IDX_W'(issue_ff);
   assign sweep_wr = go && b_valid && b_tag.interior;

   // loads only happen while no sweep is in flight, so the port is never shared
   always_comb begin
      if (sweep_wr) begin
         wr_en   = 1'b1;
         wr_addr = b_idx;
         wr_data = b_value;
      end else begin
         wr_en   = req_fire && (req_kind == KIND_LOAD);
         wr_addr = lp_start;
         wr_data = req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= wr_data;
      end
      if (issue_fire) begin
         rd_data_ff <= grid_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------- sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         a_valid_ff  <= 1'b0;
         left_old_ff <= '0;
      end else if (go) begin
         s1_valid_ff <= issue_fire;
         // slot j emits point j-1; slot 0 only primes the window
         a_valid_ff  <= s1_valid_ff && (s1_slot_ff != '0);
         if (s1_valid_ff) begin
            left_old_ff <= win_cur_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         s1_slot_ff <= issue_ff;
         if (s1_valid_ff) begin
            win_cur_ff <= rd_data_ff;
         end
         // neighbors: old u[j-2] in the window, u[j] straight from memory
         a_cur_ff          <= win_cur_ff;
         a_sum_ff          <= {left_old_ff[VALUE_WIDTH-1], left_old_ff}
                            + {rd_data_ff[VALUE_WIDTH-1], rd_data_ff};
         a_idx_ff          <= IDX_W'(s1_slot_ff - CNT_W'(1));
         a_tag_ff.interior <= (s1_slot_ff != CNT_W'(1)) && (s1_slot_ff != n_eff);
         a_tag_ff.last     <= (s1_slot_ff == n_eff);
      end
   end

   hefs_update #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX_W       (IDX_W)
   ) u_update (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .in_valid  (a_valid_ff),
      .in_tag    (a_tag_ff),
      .in_idx    (a_idx_ff),
      .in_cur    (a_cur_ff),
      .in_sum    (a_sum_ff),
      .lam       (lam_ff),
      .out_valid (b_valid),
      .out_tag   (b_tag),
      .out_idx   (b_idx),
      .out_value (b_value)
   );

   // ---------------------------------------------------------------- results
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= b_valid;
      end
      if (go && b_valid) begin
         rsp_index_ff <= POINT_INDEX_WIDTH'(b_idx);
         rsp_value_ff <= b_value;
         rsp_last_ff  <= b_tag.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_index = rsp_index_ff;
   assign rsp_point_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   // an advance request always starts a sweep
   a_advance_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_ADVANCE |=> state_ff == ST_SWEEP)
      else $error("advance request did not start a sweep");

   // the flagged result is the final point in use
   a_last_is_final_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last
         |-> rsp_point_index == POINT_INDEX_WIDTH'(n_eff - CNT_W'(1)))
      else $error("last flag on a point that is not the final one");

   // sweep write-back never overlaps the load port or an idle sequencer
   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      sweep_wr |-> state_ff != ST_IDLE && !req_ready)
      else $error("sweep write-back while the block takes requests");

endmodule
